>>> rtl/hpsc_pkg.sv
package hpsc_pkg;

  // Port count and derived widths
  localparam int NUM_PORTS = 8;
  localparam int PORT_W    = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int BM_BYTES  = (NUM_PORTS + 1 + 7) / 8;
  localparam int BM_W      = NUM_PORTS + 1;

  // Item kinds
  typedef enum logic [2:0] {
    OP_CONTROL    = 3'd0,
    OP_IN         = 3'd1,
    OP_OUT        = 3'd2,
    OP_CONNECT    = 3'd3,
    OP_DISCONNECT = 3'd4
  } op_e;

  // Handshake answers
  typedef enum logic [1:0] {
    RC_OK     = 2'd0,
    RC_STALL  = 2'd1,
    RC_NAK    = 2'd2,
    RC_BABBLE = 2'd3
  } rc_e;

  // Control request codes (type byte, request number)
  localparam logic [15:0] REQ_GET_DEV_STATUS   = 16'h8000;
  localparam logic [15:0] REQ_CLR_DEV_FEATURE  = 16'h0001;
  localparam logic [15:0] REQ_CLR_EP_FEATURE   = 16'h0201;
  localparam logic [15:0] REQ_SET_DEV_FEATURE  = 16'h0003;
  localparam logic [15:0] REQ_SET_ADDRESS      = 16'h0005;
  localparam logic [15:0] REQ_SET_CONFIG       = 16'h0009;
  localparam logic [15:0] REQ_SET_INTERFACE    = 16'h000B;
  localparam logic [15:0] REQ_GET_CONFIG       = 16'h8008;
  localparam logic [15:0] REQ_GET_INTERFACE    = 16'h800A;
  localparam logic [15:0] REQ_GET_HUB_STATUS   = 16'hA000;
  localparam logic [15:0] REQ_GET_PORT_STATUS  = 16'hA300;
  localparam logic [15:0] REQ_CLR_HUB_FEATURE  = 16'h2001;
  localparam logic [15:0] REQ_SET_HUB_FEATURE  = 16'h2003;
  localparam logic [15:0] REQ_SET_PORT_FEATURE = 16'h2303;
  localparam logic [15:0] REQ_CLR_PORT_FEATURE = 16'h2301;

  // Feature selectors
  localparam logic [15:0] FS_REMOTE_WAKEUP = 16'd1;
  localparam logic [15:0] FS_ENDPOINT_HALT = 16'd0;
  localparam logic [15:0] FS_HUB_LOCAL_PWR = 16'd0;
  localparam logic [15:0] FS_HUB_OVER_CUR  = 16'd1;
  localparam logic [15:0] FS_PORT_ENABLE   = 16'd1;
  localparam logic [15:0] FS_PORT_SUSPEND  = 16'd2;
  localparam logic [15:0] FS_PORT_RESET    = 16'd4;
  localparam logic [15:0] FS_PORT_POWER    = 16'd8;
  localparam logic [15:0] FS_C_CONNECTION  = 16'd16;
  localparam logic [15:0] FS_C_ENABLE      = 16'd17;
  localparam logic [15:0] FS_C_SUSPEND     = 16'd18;
  localparam logic [15:0] FS_C_OVER_CUR    = 16'd19;
  localparam logic [15:0] FS_C_RESET       = 16'd20;

  localparam logic [15:0] EP1_IN_ADDR = 16'h0081;
  localparam logic [3:0]  STATUS_EP   = 4'd1;

  // Port status and change bit positions
  localparam int ST_CONN    = 0;
  localparam int ST_ENABLE  = 1;
  localparam int ST_SUSPEND = 2;
  localparam int ST_LOWSPD  = 9;
  localparam int CH_CONN    = 0;
  localparam int CH_ENABLE  = 1;
  localparam int CH_SUSPEND = 2;
  localparam int CH_OVERCUR = 3;
  localparam int CH_RESET   = 4;

  typedef logic [9:0] status_t;
  typedef logic [4:0] change_t;
  localparam status_t STATUS_RESET = 10'h100;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] request;
    logic [15:0] feature_value;
    logic [15:0] port_index;
    logic [3:0]  endpoint;
    logic [9:0]  buffer_len;
    logic [2:0]  event_port;
    logic        low_speed;
  } req_t;

  typedef struct packed {
    logic [1:0]  result_code;
    logic [2:0]  byte_count;
    logic [31:0] data_word;
    logic        reset_pulse;
    logic [2:0]  reset_port;
  } rsp_t;

  // Pipeline control between the stages
  typedef struct packed {
    logic advance;
    logic fire;
  } pipe_ctrl_t;

endpackage

>>> rtl/hpsc_req_if.sv
interface hpsc_req_if;
  import hpsc_pkg::*;

  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [15:0] request;
  logic [15:0] feature_value;
  logic [15:0] port_index;
  logic [3:0]  endpoint;
  logic [9:0]  buffer_len;
  logic [2:0]  event_port;
  logic        low_speed;

  modport source (
    output valid, op, request, feature_value, port_index, endpoint, buffer_len,
           event_port, low_speed,
    input  ready
  );
  modport sink (
    input  valid, op, request, feature_value, port_index, endpoint, buffer_len,
           event_port, low_speed,
    output ready
  );
endinterface

>>> rtl/hpsc_rsp_if.sv
interface hpsc_rsp_if;
  import hpsc_pkg::*;

  logic        valid;
  logic        ready;
  logic [1:0]  result_code;
  logic [2:0]  byte_count;
  logic [31:0] data_word;
  logic        reset_pulse;
  logic [2:0]  reset_port;

  modport source (
    output valid, result_code, byte_count, data_word, reset_pulse, reset_port,
    input  ready
  );
  modport sink (
    input  valid, result_code, byte_count, data_word, reset_pulse, reset_port,
    output ready
  );
endinterface

>>> rtl/usb_hub_port_status_controller.sv
// A request beat goes through the input register and then the result register.
// Throughput: one beat per cycle while responses are taken. The input register
// can fill while the result register stalls; the port state read-modify-write
// lies between the two registers. Reset (async, active low): pipeline empty,
// every port powered only, change bits, device presence and remote wakeup cleared.
module usb_hub_port_status_controller (
  input  logic       clk_i,
  input  logic       rst_ni,
  hpsc_req_if.sink   req_i,
  hpsc_rsp_if.source rsp_o
);
  import hpsc_pkg::*;

  req_t       req_item;
  req_t       stage_item;
  logic       stage_valid;
  rsp_t       eng_rsp;
  rsp_t       out_rsp;
  pipe_ctrl_t ctrl;

  // Gather the request beat
  assign req_item.op            = req_i.op;
  assign req_item.request       = req_i.request;
  assign req_item.feature_value = req_i.feature_value;
  assign req_item.port_index    = req_i.port_index;
  assign req_item.endpoint      = req_i.endpoint;
  assign req_item.buffer_len    = req_i.buffer_len;
  assign req_item.event_port    = req_i.event_port;
  assign req_item.low_speed     = req_i.low_speed;

  hpsc_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (req_i.valid),
    .item_i    (req_item),
    .advance_i (ctrl.advance),
    .ready_o   (req_i.ready),
    .valid_o   (stage_valid),
    .item_o    (stage_item)
  );

  hpsc_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (ctrl.fire),
    .item_i (stage_item),
    .rsp_o  (eng_rsp)
  );

  hpsc_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stage_valid),
    .rsp_i   (eng_rsp),
    .ready_i (rsp_o.ready),
    .ctrl_o  (ctrl),
    .valid_o (rsp_o.valid),
    .rsp_o   (out_rsp)
  );

  // Drive the response beat
  assign rsp_o.result_code = out_rsp.result_code;
  assign rsp_o.byte_count  = out_rsp.byte_count;
  assign rsp_o.data_word   = out_rsp.data_word;
  assign rsp_o.reset_pulse = out_rsp.reset_pulse;
  assign rsp_o.reset_port  = out_rsp.reset_port;

endmodule

>>> rtl/hpsc_in_stage.sv
module hpsc_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  hpsc_pkg::req_t    item_i,
  input  logic              advance_i,
  output logic              ready_o,
  output logic              valid_o,
  output hpsc_pkg::req_t    item_o
);
  import hpsc_pkg::*;

  logic valid_q, valid_d;
  req_t item_q;

  // Stage is free when empty or when its beat moves on this cycle
  assign ready_o = !valid_q || advance_i;
  assign valid_d = valid_i ? 1'b1 : (advance_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> rtl/hpsc_engine.sv
module hpsc_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  hpsc_pkg::req_t    item_i,
  output hpsc_pkg::rsp_t    rsp_o
);
  import hpsc_pkg::*;

  status_t              status_q  [NUM_PORTS];
  status_t              status_d  [NUM_PORTS];
  change_t              change_q  [NUM_PORTS];
  change_t              change_d  [NUM_PORTS];
  logic [NUM_PORTS-1:0] present_q, present_d;
  logic                 wakeup_q, wakeup_d;

  logic [15:0]          port_n;
  logic                 port_ok;
  logic [PORT_W-1:0]    port_sel;
  logic                 evp_ok;
  logic [PORT_W-1:0]    evp_sel;
  logic [31:0]          bitmap;
  logic [NUM_PORTS-1:0] conn_vec;
  logic [NUM_PORTS-1:0] enable_vec;
  rsp_t                 rsp;

  // Port addressing for control requests and events
  assign port_n   = item_i.port_index - 16'd1;
  assign port_ok  = 32'(port_n) < 32'(NUM_PORTS);
  assign port_sel = port_n[PORT_W-1:0];
  assign evp_ok   = 32'(item_i.event_port) < 32'(NUM_PORTS);
  assign evp_sel  = PORT_W'(item_i.event_port);

  // Status change bitmap, bit 0 is the hub itself
  always_comb begin
    bitmap = '0;
    for (int i = 0; i < NUM_PORTS; i++) begin
      bitmap[i+1] = |change_q[i];
    end
  end

  // One pass: decode, answer, read-modify-write of one port
  always_comb begin
    status_d  = status_q;
    change_d  = change_q;
    present_d = present_q;
    wakeup_d  = wakeup_q;
    rsp       = '0;
    rsp.result_code = RC_OK;

    unique case (item_i.op)
      OP_CONTROL: begin
        unique case (item_i.request) inside
          REQ_GET_DEV_STATUS: begin
            rsp.byte_count = 3'd2;
            rsp.data_word  = {30'd0, wakeup_q, 1'b1};
          end
          REQ_CLR_DEV_FEATURE: begin
            if (item_i.feature_value == FS_REMOTE_WAKEUP) wakeup_d = 1'b0;
            else rsp.result_code = RC_STALL;
          end
          REQ_CLR_EP_FEATURE: begin
            if (item_i.feature_value == FS_ENDPOINT_HALT && item_i.port_index != EP1_IN_ADDR)
              rsp.result_code = RC_STALL;
          end
          REQ_SET_DEV_FEATURE: begin
            if (item_i.feature_value == FS_REMOTE_WAKEUP) wakeup_d = 1'b1;
            else rsp.result_code = RC_STALL;
          end
          REQ_SET_ADDRESS, REQ_SET_CONFIG, REQ_SET_INTERFACE: begin
            rsp.result_code = RC_OK;
          end
          REQ_GET_CONFIG: begin
            rsp.byte_count = 3'd1;
            rsp.data_word  = 32'd1;
          end
          REQ_GET_INTERFACE: begin
            rsp.byte_count = 3'd1;
          end
          REQ_GET_HUB_STATUS: begin
            rsp.byte_count = 3'd4;
          end
          REQ_GET_PORT_STATUS: begin
            if (!port_ok) begin
              rsp.result_code = RC_STALL;
            end else begin
              rsp.byte_count = 3'd4;
              rsp.data_word  = {11'd0, change_q[port_sel], 6'd0, status_q[port_sel]};
            end
          end
          REQ_CLR_HUB_FEATURE, REQ_SET_HUB_FEATURE: begin
            if (item_i.feature_value != FS_HUB_LOCAL_PWR &&
                item_i.feature_value != FS_HUB_OVER_CUR)
              rsp.result_code = RC_STALL;
          end
          REQ_SET_PORT_FEATURE: begin
            if (!port_ok) begin
              rsp.result_code = RC_STALL;
            end else if (item_i.feature_value == FS_PORT_SUSPEND) begin
              status_d[port_sel][ST_SUSPEND] = 1'b1;
            end else if (item_i.feature_value == FS_PORT_RESET) begin
              if (present_q[port_sel]) begin
                rsp.reset_pulse = 1'b1;
                rsp.reset_port  = port_n[2:0];
                change_d[port_sel][CH_RESET]  = 1'b1;
                status_d[port_sel][ST_ENABLE] = 1'b1;
              end
            end else if (item_i.feature_value != FS_PORT_POWER) begin
              rsp.result_code = RC_STALL;
            end
          end
          REQ_CLR_PORT_FEATURE: begin
            if (!port_ok) begin
              rsp.result_code = RC_STALL;
            end else begin
              case (item_i.feature_value)
                FS_PORT_ENABLE:  status_d[port_sel][ST_ENABLE]  = 1'b0;
                FS_PORT_SUSPEND: status_d[port_sel][ST_SUSPEND] = 1'b0;
                FS_C_CONNECTION: change_d[port_sel][CH_CONN]    = 1'b0;
                FS_C_ENABLE:     change_d[port_sel][CH_ENABLE]  = 1'b0;
                FS_C_SUSPEND:    change_d[port_sel][CH_SUSPEND] = 1'b0;
                FS_C_OVER_CUR:   change_d[port_sel][CH_OVERCUR] = 1'b0;
                FS_C_RESET:      change_d[port_sel][CH_RESET]   = 1'b0;
                default:         rsp.result_code = RC_STALL;
              endcase
            end
          end
          default: rsp.result_code = RC_STALL;
        endcase
      end

      // Status-change poll
      OP_IN: begin
        if (item_i.endpoint != STATUS_EP) begin
          rsp.result_code = RC_STALL;
        end else if (item_i.buffer_len != 10'd1 && 32'(item_i.buffer_len) < 32'(BM_BYTES)) begin
          rsp.result_code = RC_BABBLE;
        end else if (bitmap == '0) begin
          rsp.result_code = RC_NAK;
        end else if (item_i.buffer_len == 10'd1) begin
          rsp.byte_count = 3'd1;
          rsp.data_word  = {24'd0, bitmap[7:0]};
        end else begin
          rsp.byte_count = 3'(BM_BYTES);
          rsp.data_word  = bitmap;
        end
      end

      OP_OUT: rsp.result_code = RC_STALL;

      OP_CONNECT: begin
        if (evp_ok && !present_q[evp_sel]) begin
          present_d[evp_sel]           = 1'b1;
          status_d[evp_sel][ST_CONN]   = 1'b1;
          status_d[evp_sel][ST_LOWSPD] = item_i.low_speed;
          change_d[evp_sel][CH_CONN]   = 1'b1;
        end
      end

      OP_DISCONNECT: begin
        if (evp_ok && present_q[evp_sel]) begin
          present_d[evp_sel]           = 1'b0;
          status_d[evp_sel][ST_CONN]   = 1'b0;
          status_d[evp_sel][ST_ENABLE] = 1'b0;
          change_d[evp_sel][CH_CONN]   = 1'b1;
          if (status_q[evp_sel][ST_ENABLE]) change_d[evp_sel][CH_ENABLE] = 1'b1;
        end
      end

      default: rsp.result_code = RC_OK;
    endcase
  end

  // Port state, updated when a beat moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        status_q[i] <= STATUS_RESET;
        change_q[i] <= '0;
      end
      present_q <= '0;
      wakeup_q  <= 1'b0;
    end else if (fire_i) begin
      status_q  <= status_d;
      change_q  <= change_d;
      present_q <= present_d;
      wakeup_q  <= wakeup_d;
    end
  end

  assign rsp_o = rsp;

  always_comb begin
    for (int i = 0; i < NUM_PORTS; i++) begin
      conn_vec[i]   = status_q[i][ST_CONN];
      enable_vec[i] = status_q[i][ST_ENABLE];
    end
  end

  // Connect bit tracks device presence
  a_conn_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conn_vec == present_q) else $error("port connect bit disagrees with presence");

  // A port is only enabled while it holds a device
  a_enable_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (enable_vec & ~present_q) == '0) else $error("enabled port without device");

  // A reset pulse always comes with an ok answer
  a_reset_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.reset_pulse |-> (rsp.result_code == RC_OK)) else $error("reset pulse on error");

  // No data without valid bytes
  a_empty_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.byte_count == 3'd0) |-> (rsp.data_word == '0)) else $error("data without bytes");

endmodule

>>> rtl/hpsc_out_stage.sv
module hpsc_out_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  hpsc_pkg::rsp_t        rsp_i,
  input  logic                  ready_i,
  output hpsc_pkg::pipe_ctrl_t  ctrl_o,
  output logic                  valid_o,
  output hpsc_pkg::rsp_t        rsp_o
);
  import hpsc_pkg::*;

  logic valid_q;
  rsp_t rsp_q;
  pipe_ctrl_t ctrl;

  // Result register takes a new beat when empty or being drained
  assign ctrl.advance = !valid_q || ready_i;
  assign ctrl.fire    = ctrl.advance && valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl.advance) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.fire) begin
      rsp_q <= rsp_i;
    end
  end

  assign ctrl_o  = ctrl;
  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule
